// ===== rtl/core/rths_pkg.sv =====
// Shared types and constants for the ray/triangle hit scan unit.
`default_nettype none
package rths_pkg;
  // Register indexes
  localparam int unsigned RegOriginX = 0;
  localparam int unsigned RegOriginY = 1;
  localparam int unsigned RegOriginZ = 2;
  localparam int unsigned RegDirX = 3;
  localparam int unsigned RegDirY = 4;
  localparam int unsigned RegDirZ = 5;
  localparam int unsigned RegDetEps = 6;
  localparam int unsigned RegDistEps = 7;
  localparam int unsigned NumRegs = 8;

  // Controller states: idle and one state per datapath step (ST_DONE is not used)
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_H,
    ST_DET,
    ST_Q,
    ST_V,
    ST_T,
    ST_FLIP,
    ST_CMP,
    ST_DONE
  } rths_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic do_edge;
    logic do_h;
    logic do_det;
    logic do_q;
    logic do_v;
    logic do_t;
    logic do_flip;
    logic do_cmp;
  } rths_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/rths_if.sv =====
// Valid/ready channel interface.
`default_nettype none
interface rths_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rths_ctrl.sv =====
// Sequencer stepping the intersection datapath through its phases.
`default_nettype none
module rths_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_busy,
  output rths_pkg::rths_cmd_t cmd,
  output logic idle
);
  rths_pkg::rths_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rths_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    idle = 1'b0;
    case (state_r)
      rths_pkg::ST_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_nxt = rths_pkg::ST_EDGE;
      end
      rths_pkg::ST_EDGE: begin cmd.do_edge = 1'b1; state_nxt = rths_pkg::ST_H; end
      rths_pkg::ST_H:    begin cmd.do_h = 1'b1;    state_nxt = rths_pkg::ST_DET; end
      rths_pkg::ST_DET:  begin cmd.do_det = 1'b1;  state_nxt = rths_pkg::ST_Q; end
      rths_pkg::ST_Q:    begin cmd.do_q = 1'b1;    state_nxt = rths_pkg::ST_V; end
      rths_pkg::ST_V:    begin cmd.do_v = 1'b1;    state_nxt = rths_pkg::ST_T; end
      rths_pkg::ST_T:    begin cmd.do_t = 1'b1;    state_nxt = rths_pkg::ST_FLIP; end
      rths_pkg::ST_FLIP: begin cmd.do_flip = 1'b1; state_nxt = rths_pkg::ST_CMP; end
      rths_pkg::ST_CMP: begin
        if (!out_busy) begin
          cmd.do_cmp = 1'b1;
          state_nxt = rths_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rths_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/rths_dp.sv =====
// Intersection datapath: edge vectors, cross/dot products, hit tests, counters.
`default_nettype none
module rths_dp #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  rths_pkg::rths_cmd_t cmd,
  input  wire logic signed [COORD_WIDTH-1:0] vtx [9],
  input  wire logic last_in,
  input  wire logic signed [COORD_WIDTH-1:0] org [3],
  input  wire logic signed [COORD_WIDTH-1:0] dir [3],
  input  wire logic [39:0] det_eps,
  input  wire logic [23:0] dist_eps,
  output logic res_valid,
  input  wire logic res_take,
  output logic res_hit,
  output logic [INDEX_WIDTH-1:0] res_tri,
  output logic [INDEX_WIDTH-1:0] res_hitnum,
  output logic res_end
);
  localparam int unsigned EW = COORD_WIDTH + 1;   // edge width
  localparam int unsigned PW = 2 * EW + 1;        // cross product width
  localparam int unsigned DW = EW + PW + 2;       // dot product width
  localparam int unsigned LW = DW / 2;            // low half of det for the eps product
  localparam int unsigned HW = DW - LW;           // high half of det
  localparam int unsigned CW = DW + 26;           // distance compare width
  localparam logic [INDEX_WIDTH-1:0] IdxMax = '1;

  logic signed [COORD_WIDTH-1:0] va_r [9];
  logic last_r;
  logic signed [EW-1:0] e1_r [3], e2_r [3], s_r [3];
  logic signed [PW-1:0] h_r [3], q_r [3];
  logic signed [DW-1:0] det_r, u_r, v_r, t_r;
  logic [LW+23:0] ddl_r;
  logic signed [HW+24:0] ddh_r;
  logic signed [CW-1:0] dd_r;
  logic [INDEX_WIDTH-1:0] cnt_r, latest_r;
  logic signed [EW-1:0] dx [3];

  always_comb begin
    for (int i = 0; i < 3; i++) dx[i] = EW'(dir[i]);
  end

  // Products for the cross steps
  function automatic logic signed [PW-1:0] crs(input logic signed [EW-1:0] a1,
      input logic signed [EW-1:0] b2, input logic signed [EW-1:0] a2,
      input logic signed [EW-1:0] b1);
    logic signed [PW-1:0] p, r;
    p = PW'(a1 * b2);
    r = PW'(a2 * b1);
    return p - r;
  endfunction

  // Operand registers and multiply phases
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r <= vtx;
      last_r <= last_in;
    end
    if (cmd.do_edge) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(va_r[3+i]) - EW'(va_r[i]);
        e2_r[i] <= EW'(va_r[6+i]) - EW'(va_r[i]);
        s_r[i] <= EW'(org[i]) - EW'(va_r[i]);
      end
    end
    if (cmd.do_h) begin
      h_r[0] <= crs(dx[1], e2_r[2], dx[2], e2_r[1]);
      h_r[1] <= crs(dx[2], e2_r[0], dx[0], e2_r[2]);
      h_r[2] <= crs(dx[0], e2_r[1], dx[1], e2_r[0]);
    end
    if (cmd.do_det) begin
      det_r <= DW'(e1_r[0] * h_r[0]) + DW'(e1_r[1] * h_r[1]) + DW'(e1_r[2] * h_r[2]);
      u_r <= DW'(s_r[0] * h_r[0]) + DW'(s_r[1] * h_r[1]) + DW'(s_r[2] * h_r[2]);
    end
    if (cmd.do_q) begin
      q_r[0] <= crs(s_r[1], e1_r[2], s_r[2], e1_r[1]);
      q_r[1] <= crs(s_r[2], e1_r[0], s_r[0], e1_r[2]);
      q_r[2] <= crs(s_r[0], e1_r[1], s_r[1], e1_r[0]);
      // dist_eps * det, low half of det
      ddl_r <= (LW+24)'(dist_eps * det_r[LW-1:0]);
    end
    if (cmd.do_v) begin
      v_r <= DW'(dx[0] * q_r[0]) + DW'(dx[1] * q_r[1]) + DW'(dx[2] * q_r[2]);
      // dist_eps * det, signed high half of det
      ddh_r <= (HW+25)'($signed({1'b0, dist_eps}) * $signed(det_r[DW-1:LW]));
    end
    if (cmd.do_t) begin
      t_r <= DW'(e2_r[0] * q_r[0]) + DW'(e2_r[1] * q_r[1]) + DW'(e2_r[2] * q_r[2]);
      dd_r <= (CW'(ddh_r) <<< LW) + $signed(CW'({1'b0, ddl_r}));
    end
    if (cmd.do_flip && det_r < 0) begin
      det_r <= -det_r;
      u_r <= -u_r;
      v_r <= -v_r;
      t_r <= -t_r;
      dd_r <= -dd_r;
    end
  end

  // Hit tests on sign-adjusted values
  logic signed [CW-1:0] rhs;
  logic signed [DW:0] uv;
  logic hit_c;
  always_comb begin
    rhs = CW'(t_r) <<< 24;
    uv = (DW+1)'(u_r) + (DW+1)'(v_r);
    hit_c = (det_r >= $signed({1'b0, det_eps})) && (u_r >= 0) && (u_r <= det_r)
         && (v_r >= 0) && (uv <= (DW+1)'(det_r)) && (dd_r < rhs);
  end

  // Result register and run counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
      cnt_r <= '0;
      latest_r <= '0;
    end else begin
      res_valid <= cmd.do_cmp || (res_valid && !res_take);
      if (cmd.do_cmp) begin
        res_hit <= hit_c;
        res_tri <= cnt_r;
        res_hitnum <= hit_c ? cnt_r : latest_r;
        res_end <= last_r;
        if (last_r) begin
          cnt_r <= '0;
          latest_r <= '0;
        end else begin
          if (hit_c) latest_r <= cnt_r;
          if (cnt_r != IdxMax) cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ray_triangle_hit_scan_unit.sv =====
// Top level of the ray/triangle hit scan unit.
// One triangle at a time is tested against the configured ray (Moller-Trumbore,
// exact integer, no division). A triangle is taken only while the controller is
// idle; its result is registered after the steps (edge vectors, h, det and u,
// q, v, t, sign fix, then the compare that writes the output register), and a
// new triangle is not taken until the compare is done. The compare waits
// while an earlier result still sits unread in the output register, which holds
// off the input. Configure through the APB port only while nothing is in flight;
// register i sits at byte address 8*i with 64-bit data (det_epsilon is 40 bits).
`default_nettype none
module ray_triangle_hit_scan_unit #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rths_if.sink   in_ch,
  rths_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [5:0] cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic cfg_pready
);
  // in_ch.data: {last, c_z,c_y,c_x, b_z,b_y,b_x, a_z,a_y,a_x}; out_ch.data:
  // {run_end, hit_number, triangle_number, hit}
  logic signed [COORD_WIDTH-1:0] org_r [3], dir_r [3];
  logic [39:0] deps_r;
  logic [23:0] dist_r;
  logic [2:0] ridx;
  logic wr;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[5:3];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '{default: '0};
      dir_r <= '{COORD_WIDTH'(0), COORD_WIDTH'(0), COORD_WIDTH'(4096)};
      deps_r <= 40'd687195;
      dist_r <= 24'd168;
    end else if (wr) begin
      case (32'(ridx))
        rths_pkg::RegOriginX: org_r[0] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegOriginY: org_r[1] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegOriginZ: org_r[2] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegDirX:    dir_r[0] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegDirY:    dir_r[1] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegDirZ:    dir_r[2] <= $signed(cfg_pwdata[COORD_WIDTH-1:0]);
        rths_pkg::RegDetEps:  deps_r <= cfg_pwdata[39:0];
        rths_pkg::RegDistEps: dist_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    case (32'(ridx))
      rths_pkg::RegOriginX: cfg_prdata = 64'($signed(org_r[0]));
      rths_pkg::RegOriginY: cfg_prdata = 64'($signed(org_r[1]));
      rths_pkg::RegOriginZ: cfg_prdata = 64'($signed(org_r[2]));
      rths_pkg::RegDirX:    cfg_prdata = 64'($signed(dir_r[0]));
      rths_pkg::RegDirY:    cfg_prdata = 64'($signed(dir_r[1]));
      rths_pkg::RegDirZ:    cfg_prdata = 64'($signed(dir_r[2]));
      rths_pkg::RegDetEps:  cfg_prdata = 64'(deps_r);
      rths_pkg::RegDistEps: cfg_prdata = 64'(dist_r);
      default: cfg_prdata = '0;
    endcase
  end

  rths_pkg::rths_cmd_t cmd;
  logic idle, res_valid, res_take, in_fire;
  logic signed [COORD_WIDTH-1:0] vtx [9];

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;
  assign res_take = out_ch.valid && out_ch.ready;
  always_comb begin
    for (int i = 0; i < 9; i++) vtx[i] = in_ch.data[i*COORD_WIDTH +: COORD_WIDTH];
  end

  rths_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(res_valid && !out_ch.ready), .cmd(cmd), .idle(idle)
  );

  logic r_hit, r_end;
  logic [INDEX_WIDTH-1:0] r_tri, r_hn;
  rths_dp #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .vtx(vtx),
    .last_in(in_ch.data[9*COORD_WIDTH]),
    .org(org_r), .dir(dir_r), .det_eps(deps_r), .dist_eps(dist_r),
    .res_valid(res_valid), .res_take(res_take), .res_hit(r_hit),
    .res_tri(r_tri), .res_hitnum(r_hn), .res_end(r_end)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.data = {r_end, r_hn, r_tri, r_hit};

  // Only one triangle in flight at a time, and no unread result is overwritten
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cmd) <= 1) else $error("multiple datapath commands");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_cmp |-> (!res_valid || res_take)) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> idle) else $error("load while busy");
endmodule
`default_nettype wire
